// File: hw/rtl/sps_pkg.sv
// shared types, character codes and result helpers for the source phrase splitter
// used by sps_front, sps_fifo, sps_back and source_phrase_splitter; no dependencies
package sps_pkg;

  // character codes
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // phrase kind codes
  localparam logic [2:0] KIND_PLAIN  = 3'd0;
  localparam logic [2:0] KIND_DIRECT = 3'd1;
  localparam logic [2:0] KIND_LINE   = 3'd2;
  localparam logic [2:0] KIND_BLOCK  = 3'd3;
  localparam logic [2:0] KIND_STRING = 3'd4;
  localparam logic [2:0] KIND_PUNCT  = 3'd5;

  localparam int unsigned MAX_RES = 3;

  typedef enum logic [4:0] {
    MODE_PLAIN  = 5'b00001,
    MODE_DIRECT = 5'b00010,
    MODE_LINE   = 5'b00100,
    MODE_BLOCK  = 5'b01000,
    MODE_STRING = 5'b10000
  } sps_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       fin;
    logic [2:0] kind;
  } sps_res_t;

  // all results caused by one input character
  typedef struct packed {
    logic [1:0]                 cnt;
    sps_res_t [MAX_RES-1:0]     res;
  } sps_bundle_t;

  function automatic logic [2:0] mode_kind(sps_mode_t m);
    logic [2:0] k;
    case (m)
      MODE_DIRECT: k = KIND_DIRECT;
      MODE_LINE:   k = KIND_LINE;
      MODE_BLOCK:  k = KIND_BLOCK;
      MODE_STRING: k = KIND_STRING;
      default:     k = KIND_PLAIN;
    endcase
    return k;
  endfunction

  function automatic sps_res_t mk_char(logic [7:0] c, logic fin, logic [2:0] kind);
    sps_res_t r;
    r.ch   = c;
    r.has  = 1'b1;
    r.fin  = fin;
    r.kind = kind;
    return r;
  endfunction

  function automatic sps_res_t mk_end(logic [2:0] kind);
    sps_res_t r;
    r.ch   = 8'h00;
    r.has  = 1'b0;
    r.fin  = 1'b1;
    r.kind = kind;
    return r;
  endfunction

endpackage

// File: hw/rtl/sps_front.sv
// front end: scanner state, classifies one character per cycle unless q_full
// depends on sps_pkg; pushes one bundle of up to three results into sps_fifo
module sps_front
  import sps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  input  logic        in_eoi,
  input  logic        q_full,
  output logic        q_push,
  output sps_bundle_t q_bundle
);

  sps_mode_t mode_r, mode_nxt;
  logic      open_r, open_nxt;
  logic      slash_r, slash_nxt;
  logic      star_r, star_nxt;

  sps_res_t [MAX_RES-1:0] slots;
  logic [1:0] cnt;
  logic       open_v;
  logic       do_plain;
  logic       is_punct;
  logic       accept;
  logic [2:0] cmt_kind;

  assign is_punct = in_ch inside {CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACK,
                                  CH_RBRACK, CH_COMMA, CH_SEMI, CH_COLON, CH_DOT};
  assign cmt_kind = (in_ch == CH_SLASH) ? KIND_LINE : KIND_BLOCK;

  always_comb begin
    mode_nxt  = mode_r;
    open_nxt  = open_r;
    slash_nxt = slash_r;
    star_nxt  = star_r;
    slots     = '0;
    cnt       = 2'd0;
    open_v    = open_r;
    do_plain  = 1'b0;
    if (in_eoi) begin
      if (slash_r) begin
        slots[cnt] = mk_char(CH_SLASH, 1'b0, KIND_PLAIN);
        cnt = cnt + 2'd1;
      end
      if (mode_r == MODE_BLOCK && star_r) begin
        slots[cnt] = mk_char(CH_STAR, 1'b0, KIND_BLOCK);
        cnt = cnt + 2'd1;
      end
      if (mode_r == MODE_DIRECT || mode_r == MODE_LINE || mode_r == MODE_BLOCK ||
          mode_r == MODE_STRING) begin
        slots[cnt] = mk_end(mode_kind(mode_r));
        cnt = cnt + 2'd1;
      end else if (open_r || slash_r) begin
        slots[cnt] = mk_end(KIND_PLAIN);
        cnt = cnt + 2'd1;
      end
      mode_nxt  = MODE_PLAIN;
      open_nxt  = 1'b0;
      slash_nxt = 1'b0;
      star_nxt  = 1'b0;
    end else begin
      case (mode_r)
        MODE_DIRECT, MODE_LINE: begin
          if (in_ch == CH_NL) begin
            slots[0] = mk_end(mode_kind(mode_r));
            mode_nxt = MODE_PLAIN;
          end else begin
            slots[0] = mk_char(in_ch, 1'b0, mode_kind(mode_r));
          end
          cnt = 2'd1;
        end
        MODE_BLOCK: begin
          if (star_r) begin
            slots[0] = mk_char(CH_STAR, 1'b0, KIND_BLOCK);
            if (in_ch == CH_SLASH) begin
              slots[1] = mk_char(CH_SLASH, 1'b1, KIND_BLOCK);
              cnt      = 2'd2;
              star_nxt = 1'b0;
              mode_nxt = MODE_PLAIN;
            end else if (in_ch == CH_STAR) begin
              cnt = 2'd1;
            end else begin
              slots[1] = mk_char(in_ch, 1'b0, KIND_BLOCK);
              cnt      = 2'd2;
              star_nxt = 1'b0;
            end
          end else if (in_ch == CH_STAR) begin
            star_nxt = 1'b1;
          end else begin
            slots[0] = mk_char(in_ch, 1'b0, KIND_BLOCK);
            cnt      = 2'd1;
          end
        end
        MODE_STRING: begin
          if (in_ch == CH_QUOTE) begin
            slots[0] = mk_char(in_ch, 1'b1, KIND_STRING);
            mode_nxt = MODE_PLAIN;
          end else begin
            slots[0] = mk_char(in_ch, 1'b0, KIND_STRING);
          end
          cnt = 2'd1;
        end
        default: begin
          // plain text, also any stray mode code
          mode_nxt = MODE_PLAIN;
          do_plain = 1'b1;
          if (slash_r) begin
            slash_nxt = 1'b0;
            if (in_ch == CH_SLASH || in_ch == CH_STAR) begin
              do_plain = 1'b0;
              if (open_r) begin
                slots[cnt] = mk_end(KIND_PLAIN);
                cnt = cnt + 2'd1;
                open_nxt = 1'b0;
              end
              slots[cnt] = mk_char(CH_SLASH, 1'b0, cmt_kind);
              cnt = cnt + 2'd1;
              slots[cnt] = mk_char(in_ch, 1'b0, cmt_kind);
              cnt = cnt + 2'd1;
              mode_nxt = (in_ch == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
              star_nxt = 1'b0;
            end else begin
              slots[cnt] = mk_char(CH_SLASH, 1'b0, KIND_PLAIN);
              cnt = cnt + 2'd1;
              open_v   = 1'b1;
              open_nxt = 1'b1;
            end
          end
          if (do_plain) begin
            if (in_ch == CH_HASH || in_ch == CH_QUOTE || is_punct) begin
              if (open_v) begin
                slots[cnt] = mk_end(KIND_PLAIN);
                cnt = cnt + 2'd1;
                open_nxt = 1'b0;
              end
              if (in_ch == CH_HASH) begin
                slots[cnt] = mk_char(in_ch, 1'b0, KIND_DIRECT);
                mode_nxt = MODE_DIRECT;
              end else if (in_ch == CH_QUOTE) begin
                slots[cnt] = mk_char(in_ch, 1'b0, KIND_STRING);
                mode_nxt = MODE_STRING;
              end else begin
                slots[cnt] = mk_char(in_ch, 1'b1, KIND_PUNCT);
              end
              cnt = cnt + 2'd1;
            end else if (in_ch == CH_SLASH) begin
              slash_nxt = 1'b1;
            end else if (in_ch != CH_NL) begin
              slots[cnt] = mk_char(in_ch, 1'b0, KIND_PLAIN);
              cnt = cnt + 2'd1;
              open_nxt = 1'b1;
            end
          end
        end
      endcase
    end
  end

  assign in_ready       = !q_full;
  assign accept         = in_valid && in_ready;
  assign q_push         = accept && (cnt != 2'd0);
  assign q_bundle.cnt   = cnt;
  assign q_bundle.res   = slots;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PLAIN;
      open_r  <= 1'b0;
      slash_r <= 1'b0;
      star_r  <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      open_r  <= open_nxt;
      slash_r <= slash_nxt;
      star_r  <= star_nxt;
    end
  end

endmodule

// File: hw/rtl/sps_fifo.sv
// short bundle queue between the classifier and the result unloader
// depends on sps_pkg for the bundle type
module sps_fifo
  import sps_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  sps_bundle_t push_data,
  input  logic        pop,
  output sps_bundle_t head,
  output logic        empty,
  output logic        full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sps_bundle_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/sps_back.sv
// back end: while the output keeps up, unloads one result per cycle from the queue
// head into the output register; depends on sps_pkg; marks each bundle's last result
module sps_back
  import sps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sps_bundle_t head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output sps_res_t    out_res,
  output logic        out_last
);

  logic [1:0] idx_r;
  logic       out_valid_r;
  sps_res_t   out_res_r;
  logic       out_last_r;
  logic       load;
  logic       is_last;

  assign is_last = ((idx_r + 2'd1) == head.cnt);
  assign load    = !q_empty && (!out_valid_r || out_ready);
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      idx_r       <= is_last ? 2'd0 : idx_r + 2'd1;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= head.res[idx_r];
      out_last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

endmodule

// File: hw/rtl/source_phrase_splitter.sv
// top level of the source phrase splitter: classifier, bundle queue and result unloader
// depends on sps_pkg, sps_front, sps_fifo and sps_back
//
// usage
//  - input stream: one source character per request on in_tdata; in_tlast high marks
//    end of text, which flushes a held '/' or '*' and closes any open phrase, after
//    which the scanner is back in its reset state (the character bits are ignored)
//  - output stream: one phrase character or bare phrase end per request; out_tlast
//    is high on the last result caused by one input character
//  - each input character gives zero to three results; all results of one character
//    are formed in the accepting cycle and stored as one bundle in a short queue
//  - the results of a character pass through the bundle queue, then the output register;
//    further results of the same character follow one a cycle while the output keeps up
//  - throughput: one character per cycle while the output keeps up; the output side
//    moves one result per cycle, so the sustained input rate is set by the output
//    port and the average results per character, bursts absorbed by FIFO_DEPTH bundles
//  - in_tready drops only when the queue is full; a stalled receiver fills the
//    queue and then holds off the source, nothing is lost or repeated
//  - reset (rst_n low, synchronous) returns the scanner to plain text and empties
//    the queue and the output register
module source_phrase_splitter
  import sps_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] phrase_byte, [8] phrase_end, [15:9] zero
  output logic [3:0]  out_tuser,  // [0] has_byte, [3:1] phrase_kind
  output logic        out_tlast   // run_last
);

  // front to queue
  logic        q_push;
  sps_bundle_t q_wdata;
  logic        q_full;

  // queue to back
  sps_bundle_t q_head;
  logic        q_empty;
  logic        q_pop;

  sps_res_t    res;

  // classifier with scanner state, takes one character a cycle while the queue has room
  sps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_ch    (in_tdata),
    .in_eoi   (in_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_bundle (q_wdata)
  );

  // bundles waiting to be unloaded
  sps_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // result unloader and output register
  sps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  // pack result fields onto the stream
  assign out_tdata = {7'd0, res.fin, res.ch};
  assign out_tuser = {res.kind, res.has};

`ifndef SYNTH
  // the queue never takes a bundle while full
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("bundle pushed into full queue");

  // the unloader never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // a result without a character is always a phrase end with a zero byte
  a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[8] && out_tdata[7:0] == 8'h00))
    else $error("bare result is not a clean phrase end");

  // a pushed bundle always carries a result count of one to three
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_wdata.cnt != 2'd0))
    else $error("empty bundle pushed");
`endif

endmodule

// File: sim/tb.sv
// self-checking testbench for source_phrase_splitter: directed and random source text,
// predicted phrase results compared per field against the output stream
// depends on sps_pkg and source_phrase_splitter
module tb;
  import sps_pkg::*;

  localparam int RANDOM_ITEMS = 120;
  localparam int HOLD_CYCLES  = 40;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } text_item_t;

  typedef struct packed {
    logic [7:0] phrase_byte;
    logic       has_byte;
    logic       phrase_end;
    logic [2:0] phrase_kind;
    logic       run_last;
  } phrase_out_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  // source text still to be offered, results still owed by the block
  text_item_t  text_queue[$];
  phrase_out_t phrase_due[$];
  phrase_out_t step_buf[$];

  logic in_fire   = 1'b0;  // request taken at the last rising edge
  int   items_sent = 0;
  int   total_items = 0;
  int   err_count  = 0;
  int   hold_left  = 0;
  logic hold_done  = 1'b0;

  // scanner state of the prediction
  logic [2:0] scan_kind;
  logic       plain_open;
  logic       held_slash;
  logic       held_star;

  source_phrase_splitter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // phrase prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_scan();
    scan_kind  = KIND_PLAIN;
    plain_open = 1'b0;
    held_slash = 1'b0;
    held_star  = 1'b0;
  endfunction

  // one result of the current character, at most three per character
  function automatic void put_res(logic [7:0] ch, logic has, logic fin, logic [2:0] kind);
    phrase_out_t r;
    if (step_buf.size() >= MAX_RES) return;
    r.phrase_byte = has ? ch : 8'h00;
    r.has_byte    = has;
    r.phrase_end  = fin;
    r.phrase_kind = kind;
    r.run_last    = 1'b0;
    step_buf = {step_buf, r};
  endfunction

  function automatic logic is_punct(logic [7:0] b);
    return b == CH_LPAREN || b == CH_RPAREN || b == CH_LBRACE || b == CH_RBRACE ||
           b == CH_LBRACK || b == CH_RBRACK || b == CH_COMMA || b == CH_SEMI ||
           b == CH_COLON || b == CH_DOT;
  endfunction

  // bare end of a plain phrase that holds characters
  function automatic void close_plain();
    if (plain_open) begin
      put_res(8'h00, 1'b0, 1'b1, KIND_PLAIN);
      plain_open = 1'b0;
    end
  endfunction

  function automatic void plain_char(logic [7:0] b);
    if (b == CH_HASH) begin
      close_plain();
      put_res(b, 1'b1, 1'b0, KIND_DIRECT);
      scan_kind = KIND_DIRECT;
    end else if (b == CH_SLASH) begin
      held_slash = 1'b1;
    end else if (b == CH_QUOTE) begin
      close_plain();
      put_res(b, 1'b1, 1'b0, KIND_STRING);
      scan_kind = KIND_STRING;
    end else if (is_punct(b)) begin
      close_plain();
      put_res(b, 1'b1, 1'b1, KIND_PUNCT);
    end else if (b != CH_NL) begin
      // spaces and everything else join the plain phrase
      put_res(b, 1'b1, 1'b0, KIND_PLAIN);
      plain_open = 1'b1;
    end
  endfunction

  // all results that one accepted character causes, queued in order
  function automatic void split_char(logic [7:0] b, logic eoi);
    logic [2:0]  m;
    step_buf.delete();
    if (eoi) begin
      // flush held byte, then close whatever phrase is open
      if (held_slash) begin
        put_res(CH_SLASH, 1'b1, 1'b0, KIND_PLAIN);
        plain_open = 1'b1;
      end
      if (scan_kind == KIND_BLOCK && held_star) put_res(CH_STAR, 1'b1, 1'b0, KIND_BLOCK);
      if (scan_kind >= KIND_DIRECT && scan_kind <= KIND_STRING)
        put_res(8'h00, 1'b0, 1'b1, scan_kind);
      else
        close_plain();
      clear_scan();
    end else if (scan_kind == KIND_DIRECT || scan_kind == KIND_LINE) begin
      if (b == CH_NL) begin
        put_res(8'h00, 1'b0, 1'b1, scan_kind);
        scan_kind = KIND_PLAIN;
      end else begin
        put_res(b, 1'b1, 1'b0, scan_kind);
      end
    end else if (scan_kind == KIND_BLOCK) begin
      if (held_star) begin
        if (b == CH_SLASH) begin
          put_res(CH_STAR, 1'b1, 1'b0, KIND_BLOCK);
          put_res(CH_SLASH, 1'b1, 1'b1, KIND_BLOCK);
          held_star = 1'b0;
          scan_kind = KIND_PLAIN;
        end else if (b == CH_STAR) begin
          put_res(CH_STAR, 1'b1, 1'b0, KIND_BLOCK);
        end else begin
          put_res(CH_STAR, 1'b1, 1'b0, KIND_BLOCK);
          put_res(b, 1'b1, 1'b0, KIND_BLOCK);
          held_star = 1'b0;
        end
      end else if (b == CH_STAR) begin
        held_star = 1'b1;
      end else begin
        put_res(b, 1'b1, 1'b0, KIND_BLOCK);
      end
    end else if (scan_kind == KIND_STRING) begin
      if (b == CH_QUOTE) begin
        put_res(b, 1'b1, 1'b1, KIND_STRING);
        scan_kind = KIND_PLAIN;
      end else begin
        put_res(b, 1'b1, 1'b0, KIND_STRING);
      end
    end else begin
      scan_kind = KIND_PLAIN;
      if (held_slash) begin
        held_slash = 1'b0;
        if (b == CH_SLASH || b == CH_STAR) begin
          m = (b == CH_SLASH) ? KIND_LINE : KIND_BLOCK;
          close_plain();
          put_res(CH_SLASH, 1'b1, 1'b0, m);
          put_res(b, 1'b1, 1'b0, m);
          scan_kind = m;
          held_star = 1'b0;
        end else begin
          // held slash turns out to be a plain character
          put_res(CH_SLASH, 1'b1, 1'b0, KIND_PLAIN);
          plain_open = 1'b1;
          plain_char(b);
        end
      end else begin
        plain_char(b);
      end
    end
    if (step_buf.size() > 0) step_buf[step_buf.size() - 1].run_last = 1'b1;
    phrase_due = {phrase_due, step_buf};
  endfunction

  // ---------------------------------------------------------------------------
  // source text generation
  // ---------------------------------------------------------------------------

  function automatic void add_char(logic [7:0] b);
    text_item_t it;
    it.text_byte    = b;
    it.end_of_input = 1'b0;
    text_queue = {text_queue, it};
  endfunction

  // end of text, the character bits carry random junk
  function automatic void add_end();
    text_item_t it;
    it.text_byte    = 8'($urandom_range(255));
    it.end_of_input = 1'b1;
    text_queue = {text_queue, it};
  endfunction

  function automatic logic [7:0] word_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 8'("a" + $urandom_range(25));
    if (r < 80) return 8'("0" + $urandom_range(9));
    return 8'(" ");
  endfunction

  function automatic logic [7:0] special_char();
    logic [7:0] sp[15] = '{CH_HASH, CH_SLASH, CH_STAR, CH_QUOTE, CH_NL, CH_LPAREN,
                           CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                           CH_COMMA, CH_SEMI, CH_COLON, CH_DOT};
    return sp[$urandom_range(14)];
  endfunction

  // body of a directive, comment or string: mostly words, some specials, some any byte
  function automatic logic [7:0] body_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return word_char();
    if (r < 80) return special_char();
    return 8'($urandom_range(255));
  endfunction

  function automatic void add_body(int unsigned max_len);
    int unsigned n;
    n = $urandom_range(max_len);
    repeat (n) add_char(body_char());
  endfunction

  function automatic void fill_directed();
    add_end();                                     // empty text gives nothing
    add_char("a"); add_char(8'hFF);                // plain phrase, all-ones byte
    add_char(" "); add_char(CH_NL);                // space kept, plain newline dropped
    add_char(CH_LPAREN);                           // punctuation closes the plain phrase
    add_char(CH_HASH); add_char(8'h00); add_char(CH_NL);   // directive
    add_char(CH_SLASH); add_char(CH_SLASH); add_char(CH_NL); // line comment
    add_char(CH_SLASH); add_char(CH_STAR);         // block comment with star runs
    add_char(CH_STAR); add_char(CH_STAR); add_char("x");
    add_char(CH_STAR); add_char(CH_SLASH);
    add_char(CH_QUOTE); add_char(CH_NL); add_char(CH_QUOTE); // newline kept in string
    add_char(CH_SLASH); add_char("a");             // held slash, no comment
    add_char(CH_SLASH); add_end();                 // held slash flushed at end of text
  endfunction

  function automatic void fill_random();
    int unsigned r;
    int          start;
    start = text_queue.size();
    while (text_queue.size() - start < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 20) begin
        repeat ($urandom_range(1, 6)) add_char(word_char());
      end else if (r < 32) begin
        add_char(special_char());
      end else if (r < 40) begin
        add_char(CH_HASH); add_body(5); add_char(CH_NL);
      end else if (r < 48) begin
        add_char(CH_SLASH); add_char(CH_SLASH); add_body(5); add_char(CH_NL);
      end else if (r < 60) begin
        add_char(CH_SLASH); add_char(CH_STAR); add_body(6);
        if ($urandom_range(1)) add_char(CH_STAR);
        add_char(CH_STAR); add_char(CH_SLASH);
      end else if (r < 70) begin
        add_char(CH_QUOTE); add_body(5); add_char(CH_QUOTE);
      end else if (r < 78) begin
        if ($urandom_range(1)) add_char(CH_NL);
        else begin
          add_char(CH_SLASH); add_char(body_char());
        end
      end else if (r < 90) begin
        repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(255)));
      end else begin
        // end of text, often in the middle of an open phrase
        add_end();
      end
    end
    add_end();
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus and idling
  // ---------------------------------------------------------------------------

  // sender idles 23 then 50 then 0 percent, receiver 50 then 23 then 0 percent
  function automatic int unsigned idle_phase();
    if (items_sent < total_items / 3) return 0;
    if (items_sent < 2 * total_items / 3) return 1;
    return 2;
  endfunction

  // input driver: next request once the current one is taken or none is offered
  always @(negedge clk) begin : drive_proc
    text_item_t  it;
    int unsigned idle_pct;
    idle_pct = (idle_phase() == 0) ? 23 : (idle_phase() == 1) ? 50 : 0;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (text_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        it = text_queue.pop_front();
        in_tdata   <= it.text_byte;
        in_tlast   <= it.end_of_input;
        in_tvalid  <= 1'b1;
        items_sent <= items_sent + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output ready: random stalls, plus one long hold-off late in the run while the
  // sender keeps going, so the bundle queue fills and in_tready drops
  always @(negedge clk) begin : recv_proc
    int unsigned idle_pct;
    idle_pct = (idle_phase() == 0) ? 50 : (idle_phase() == 1) ? 23 : 0;
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && total_items > 0 && items_sent >= 3 * total_items / 4) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each accepted character, check each accepted result
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : mon_proc
    phrase_out_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) split_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (phrase_due.size() == 0) begin
          $error("unexpected result: tdata %h tuser %h tlast %b",
                 out_tdata, out_tuser, out_tlast);
          err_count++;
        end else begin
          want = phrase_due.pop_front();
          if (out_tdata[7:0] !== want.phrase_byte) begin
            $error("phrase_byte: expected %h, got %h", want.phrase_byte, out_tdata[7:0]);
            err_count++;
          end
          if (out_tdata[8] !== want.phrase_end) begin
            $error("phrase_end: expected %b, got %b", want.phrase_end, out_tdata[8]);
            err_count++;
          end
          if (out_tdata[15:9] !== 7'd0) begin
            $error("tdata padding: expected %h, got %h", 7'd0, out_tdata[15:9]);
            err_count++;
          end
          if (out_tuser[0] !== want.has_byte) begin
            $error("has_byte: expected %b, got %b", want.has_byte, out_tuser[0]);
            err_count++;
          end
          if (out_tuser[3:1] !== want.phrase_kind) begin
            $error("phrase_kind: expected %0d, got %0d", want.phrase_kind, out_tuser[3:1]);
            err_count++;
          end
          if (out_tlast !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, out_tlast);
            err_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------

  initial begin : main_proc
    rst_n = 1'b0;
    clear_scan();
    fill_directed();
    fill_random();
    total_items = text_queue.size();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // every request taken, then every owed result seen
    while (text_queue.size() != 0 || in_tvalid) @(negedge clk);
    while (phrase_due.size() != 0) @(negedge clk);
    // catch stray results after the last expected one
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : limit_proc
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: source_phrase_splitter.f
hw/rtl/sps_pkg.sv
hw/rtl/sps_front.sv
hw/rtl/sps_fifo.sv
hw/rtl/sps_back.sv
hw/rtl/source_phrase_splitter.sv
sim/tb.sv
